// ===== src/assert_macros.svh =====
// Assertion helpers used by occupancy_grid_square_dilation.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define OGSD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define OGSD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define OGSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ogsd_pkg.sv =====
package ogsd_pkg;

   // Map limits.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_RADIUS = 16;

   // Widths of counters, registers and history words.
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int DIM_W  = 11;
   localparam int RAD_W  = 5;
   localparam int ROW_W  = 11;
   localparam int HIST_W = 2 * MAX_RADIUS;
   localparam int WIN_W  = HIST_W + 1;
   localparam int CNT_W  = $clog2(WIN_W + 1);
   localparam int SPOS_W = ROW_W + COL_W;

   // Configuration port.
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [1:0] REG_IMAGE_WIDTH      = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT     = 2'd1;
   localparam logic [1:0] REG_INFLATION_RADIUS = 2'd2;

   localparam logic [DIM_W-1:0] RESET_IMAGE_WIDTH      = 11'd640;
   localparam logic [DIM_W-1:0] RESET_IMAGE_HEIGHT     = 11'd480;
   localparam logic [RAD_W-1:0] RESET_INFLATION_RADIUS = 5'd4;

   // Output shades.
   localparam logic [7:0] GRAY_FREE     = 8'd255;
   localparam logic [7:0] GRAY_OCCUPIED = 8'd0;

   // Clamped configuration as seen by the datapath.
   typedef struct packed {
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [RAD_W-1:0]  radius;
      logic [SPOS_W-1:0] lag;
   } cfg_type;

   // Ones in the bits below n, over a history word.
   function automatic logic [HIST_W-1:0] low_mask_hist(input logic [CNT_W-1:0] n);
      logic [HIST_W-1:0] m;
      for (int i = 0; i < HIST_W; i++) begin
         m[i] = (CNT_W'(i) < n);
      end
      return m;
   endfunction

   // Ones in the bits below n, over the horizontal window.
   function automatic logic [WIN_W-1:0] low_mask_win(input logic [CNT_W-1:0] n);
      logic [WIN_W-1:0] m;
      for (int i = 0; i < WIN_W; i++) begin
         m[i] = (CNT_W'(i) < n);
      end
      return m;
   endfunction

endpackage

// ===== src/ogsd_csr.sv =====
module ogsd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ogsd_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [ogsd_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [ogsd_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready,
   output ogsd_pkg::cfg_type            cfg,
   output logic                         restart
);
   import ogsd_pkg::*;

   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic [RAD_W-1:0] radius_ff;
   logic [1:0]       reg_idx;
   logic             wr;
   logic [DIM_W-1:0] width_c;
   logic [DIM_W-1:0] height_c;
   logic [RAD_W-1:0] radius_c;
   logic [RAD_W+DIM_W-1:0] rw_prod;

   // The port never inserts wait states.
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Any write to a mapped register restarts the frame.
   assign restart = wr && (reg_idx == REG_IMAGE_WIDTH || reg_idx == REG_IMAGE_HEIGHT ||
                           reg_idx == REG_INFLATION_RADIUS);

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_IMAGE_WIDTH;
         height_ff <= RESET_IMAGE_HEIGHT;
         radius_ff <= RESET_INFLATION_RADIUS;
      end else if (wr) begin
         case (reg_idx)
            REG_IMAGE_WIDTH:      width_ff  <= csr_pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT:     height_ff <= csr_pwdata[DIM_W-1:0];
            REG_INFLATION_RADIUS: radius_ff <= csr_pwdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back the raw register values.
   always_comb begin
      case (reg_idx)
         REG_IMAGE_WIDTH:      csr_prdata = CSR_DW'(width_ff);
         REG_IMAGE_HEIGHT:     csr_prdata = CSR_DW'(height_ff);
         REG_INFLATION_RADIUS: csr_prdata = CSR_DW'(radius_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // Clamp the registers to the supported map and window sizes.
   always_comb begin
      if (width_ff == '0) begin
         width_c = DIM_W'(1);
      end else if (width_ff > DIM_W'(MAX_WIDTH)) begin
         width_c = DIM_W'(MAX_WIDTH);
      end else begin
         width_c = width_ff;
      end
      if (height_ff == '0) begin
         height_c = DIM_W'(1);
      end else if (height_ff > DIM_W'(MAX_HEIGHT)) begin
         height_c = DIM_W'(MAX_HEIGHT);
      end else begin
         height_c = height_ff;
      end
      if (radius_ff > RAD_W'(MAX_RADIUS)) begin
         radius_c = RAD_W'(MAX_RADIUS);
      end else begin
         radius_c = radius_ff;
      end
   end

   // Stream distance between a pixel and the cell whose window it completes.
   assign rw_prod = {{DIM_W{1'b0}}, radius_c} * {{RAD_W{1'b0}}, width_c};

   always_comb begin
      cfg.width  = width_c;
      cfg.height = height_c;
      cfg.radius = radius_c;
      cfg.lag    = SPOS_W'(rw_prod) + SPOS_W'(radius_c);
   end

endmodule

// ===== src/occupancy_grid_square_dilation.sv =====
// A cell is loaded into the output register from the back stage, which took in the transfer
// of the pixel (or pad) that lies radius rows plus radius pixels after it in the stream.
// Throughput: one item per cycle, set by the column history memory, which takes one
// read and one write each cycle. While a result waits under stall, one more item may
// enter the back stage, and then the input stalls until the result leaves.
// Reset: counters, row window and output valid clear at once; the history memory is
// never cleared, since bits from rows outside the frame are masked by row position.
`include "assert_macros.svh"

module occupancy_grid_square_dilation (
   input  logic                         clock,
   input  logic                         reset,
   // Input pixels
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_red,
   input  logic [7:0]                   req_green,
   input  logic [7:0]                   req_blue,
   input  logic                         req_pad,
   // Inflated cells
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [9:0]                   rsp_out_x,
   output logic [9:0]                   rsp_out_y,
   output logic                         rsp_occupied,
   output logic [7:0]                   rsp_gray,
   output logic                         rsp_frame_end,
   // Configuration
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ogsd_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [ogsd_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [ogsd_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import ogsd_pkg::*;

   cfg_type cfg;
   logic    restart;

   // Stream counters.
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in;
   logic [COL_W-1:0]  emit_col_ff, emit_col_in;
   logic [ROW_W-1:0]  emit_row_ff, emit_row_in;
   logic [SPOS_W-1:0] spos_ff, spos_in;

   // Front stage decode.
   logic              acc, ignore, proc, col_bad, col_ok, in_frame, obstacle;
   logic [DIM_W-1:0]  in_col_ext, emit_col_ext, wm1, exr, col_over;
   logic [ROW_W-1:0]  row_over;
   logic [CNT_W-1:0]  two_r, hi_n, lo_n, jmax, jtop, jmin;
   logic [HIST_W-1:0] hmask;
   logic [WIN_W-1:0]  omask;
   logic              emit, last, wrap_restart;

   // Back stage.
   logic              s1_valid_ff;
   logic              s1_obst_ff, s1_emit_ff, s1_last_ff;
   logic [HIST_W-1:0] s1_hmask_ff;
   logic [WIN_W-1:0]  s1_omask_ff;
   logic [COL_W-1:0]  s1_addr_ff;
   logic [9:0]        s1_x_ff, s1_y_ff;
   logic              fwd_ff, fwd_in;
   logic [HIST_W-1:0] fwd_data_ff, rd_data_ff;
   logic [HIST_W-1:0] hist, new_hist;
   logic [HIST_W-1:0] row_win_ff;
   logic              vert, occ, out_free, s1_done;

   // Output register.
   logic              rsp_valid_ff, rsp_occupied_ff, rsp_frame_end_ff;
   logic [9:0]        rsp_out_x_ff, rsp_out_y_ff;
   logic [7:0]        rsp_gray_ff;

   // Column history: per column, obstacle bits of the latest rows, newest in bit 0.
   logic [HIST_W-1:0] hist_mem [MAX_WIDTH];

   ogsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .restart     (restart)
   );

   // Handshake: the back stage moves when the output register is free or draining.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_done   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign acc       = req_valid && !req_stall;

   // Classify the transfer and build the window masks from the stream position.
   always_comb begin
      in_frame   = in_row_ff < cfg.height;
      in_col_ext = {1'b0, in_col_ff};
      col_ok     = in_col_ext < cfg.width;
      ignore     = in_frame && req_pad;
      proc       = acc && !ignore && col_ok;
      col_bad    = acc && !ignore && !col_ok;
      obstacle   = in_frame && !req_pad && (req_red == 8'd0) && (req_green == 8'd0) &&
                   (req_blue == 8'd0);

      // Vertical mask: history rows must lie inside 0..height-1.
      two_r    = {cfg.radius, 1'b0};
      hi_n     = (in_row_ff < ROW_W'(two_r)) ? in_row_ff[CNT_W-1:0] : two_r;
      row_over = in_row_ff - cfg.height;
      if (in_row_ff <= cfg.height) begin
         lo_n = '0;
      end else if (row_over > ROW_W'(HIST_W)) begin
         lo_n = CNT_W'(HIST_W);
      end else begin
         lo_n = row_over[CNT_W-1:0];
      end
      hmask = low_mask_hist(hi_n) & ~low_mask_hist(lo_n);

      // Horizontal mask: window columns must lie inside 0..width-1.
      emit_col_ext = {1'b0, emit_col_ff};
      exr          = emit_col_ext + DIM_W'(cfg.radius);
      jmax         = (exr < DIM_W'(two_r)) ? exr[CNT_W-1:0] : two_r;
      jtop         = jmax + 1'b1;
      wm1          = cfg.width - 1'b1;
      col_over     = exr - wm1;
      if (exr <= wm1) begin
         jmin = '0;
      end else if (col_over > DIM_W'(WIN_W)) begin
         jmin = CNT_W'(WIN_W);
      end else begin
         jmin = col_over[CNT_W-1:0];
      end
      omask = low_mask_win(jtop) & ~low_mask_win(jmin);

      emit = (spos_ff >= cfg.lag) && (emit_row_ff < cfg.height);
      last = (emit_row_ff == cfg.height - 1'b1) && (emit_col_ext == wm1);
   end

   // Counter updates for a processed transfer.
   always_comb begin
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      emit_col_in  = emit_col_ff;
      emit_row_in  = emit_row_ff;
      spos_in      = spos_ff;
      wrap_restart = 1'b0;
      if (proc) begin
         if (emit) begin
            if (emit_col_ext + 1'b1 >= cfg.width) begin
               emit_col_in = '0;
               emit_row_in = emit_row_ff + 1'b1;
            end else begin
               emit_col_in = emit_col_ff + 1'b1;
            end
         end
         spos_in = spos_ff + 1'b1;
         if (in_col_ext + 1'b1 >= cfg.width) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
            if (in_row_ff == '1) begin
               wrap_restart = 1'b1;
            end
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart || col_bad || wrap_restart || (proc && emit && last)) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         emit_col_ff <= '0;
         emit_row_ff <= '0;
         spos_ff     <= '0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         emit_col_ff <= emit_col_in;
         emit_row_ff <= emit_row_in;
         spos_ff     <= spos_in;
      end
   end

   // History memory: read for the entering transfer, write back from the back stage.
   assign fwd_in = s1_done && (s1_addr_ff == in_col_ff);

   always_ff @(posedge clock) begin
      if (s1_done) begin
         hist_mem[s1_addr_ff] <= new_hist;
      end
      if (proc) begin
         rd_data_ff <= hist_mem[in_col_ff];
      end
   end

   // Back stage valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (proc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_done) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Back stage payload, including the bypass of a same-column write.
   always_ff @(posedge clock) begin
      if (proc) begin
         s1_obst_ff  <= obstacle;
         s1_emit_ff  <= emit;
         s1_last_ff  <= last;
         s1_hmask_ff <= hmask;
         s1_omask_ff <= omask;
         s1_addr_ff  <= in_col_ff;
         s1_x_ff     <= emit_col_ff;
         s1_y_ff     <= emit_row_ff[9:0];
         fwd_ff      <= fwd_in;
         fwd_data_ff <= new_hist;
      end
   end

   // Vertical OR over the column, then horizontal OR over the row window.
   always_comb begin
      hist     = fwd_ff ? fwd_data_ff : rd_data_ff;
      vert     = s1_obst_ff | (|(hist & s1_hmask_ff));
      new_hist = {hist[HIST_W-2:0], s1_obst_ff};
      occ      = |({row_win_ff, vert} & s1_omask_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_win_ff <= '0;
      end else if (s1_done) begin
         row_win_ff <= {row_win_ff[HIST_W-2:0], vert};
      end
   end

   // Output register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_done && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (s1_done && s1_emit_ff) begin
         rsp_out_x_ff     <= s1_x_ff;
         rsp_out_y_ff     <= s1_y_ff;
         rsp_occupied_ff  <= occ;
         rsp_gray_ff      <= occ ? GRAY_OCCUPIED : GRAY_FREE;
         rsp_frame_end_ff <= s1_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_out_x_ff;
   assign rsp_out_y     = rsp_out_y_ff;
   assign rsp_occupied  = rsp_occupied_ff;
   assign rsp_gray      = rsp_gray_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // Checks on the counters, the back stage and the output.
   `OGSD_ASSERT(a_in_col_range, col_ok, "input column beyond width")
   `OGSD_ASSERT(a_emit_row_range, in_frame || (emit_row_ff < cfg.height), "emit row too high")
   `OGSD_ASSERT_NEXT(a_s1_held, s1_valid_ff && !out_free, s1_valid_ff, "stalled item lost")
   `OGSD_ASSERT_IMPL(a_end_col, rsp_valid && rsp_frame_end, {1'b0, rsp_out_x} == wm1, "end column")

endmodule

// ===== dv/occupancy_grid_square_dilation_test.sv =====
`timescale 1ns / 1ps

module occupancy_grid_square_dilation_test;
   import ogsd_pkg::*;

   typedef struct packed {
      logic [9:0] x;
      logic [9:0] y;
      logic       occupied;
      logic [7:0] gray;
      logic       frame_end;
   } inflated_cell_type;

   // Tracks the map settings and the dilation window, and queues the cells
   // that the block must emit.
   class inflation_tracker_type;
      logic [10:0]       width_reg;
      logic [10:0]       height_reg;
      logic [4:0]        radius_reg;
      bit [63:0]         col_bits [MAX_WIDTH];
      bit [63:0]         row_bits;
      int                in_x, in_y, out_col, out_row;
      inflated_cell_type due_cells [$];
      int                errors;

      function new();
         foreach (col_bits[i]) col_bits[i] = '0;
         row_bits   = '0;
         width_reg  = RESET_IMAGE_WIDTH;
         height_reg = RESET_IMAGE_HEIGHT;
         radius_reg = RESET_INFLATION_RADIUS;
         errors     = 0;
         rewind();
      endfunction

      function void rewind();
         in_x    = 0;
         in_y    = 0;
         out_col = 0;
         out_row = 0;
      endfunction

      function int clamp_to(int v, int lo, int hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function int width_used();
         return clamp_to(width_reg, 1, MAX_WIDTH);
      endfunction

      function int height_used();
         return clamp_to(height_reg, 1, MAX_HEIGHT);
      endfunction

      function int radius_used();
         return clamp_to(radius_reg, 0, MAX_RADIUS);
      endfunction

      // Number of stream positions between a cell and the transfer that releases it.
      function int flush_length();
         return radius_used() * width_used() + radius_used();
      endfunction

      function int pending();
         return due_cells.size();
      endfunction

      // A write to a mapped register restarts the frame; cells already queued are kept.
      function void write_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_IMAGE_WIDTH: width_reg = value[10:0];
            REG_IMAGE_HEIGHT: height_reg = value[10:0];
            REG_INFLATION_RADIUS: radius_reg = value[4:0];
            default: return;
         endcase
         rewind();
      endfunction

      function logic [31:0] reg_value(logic [1:0] idx);
         case (idx)
            REG_IMAGE_WIDTH: return 32'(width_reg);
            REG_IMAGE_HEIGHT: return 32'(height_reg);
            default: return 32'(radius_reg);
         endcase
      endfunction

      // Note one accepted input transfer and queue the cell it releases, if any.
      function void take_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                               logic pad_in);
         int                w, h, r, s, lag, ex, ey, c0, c1, j, row;
         bit                pad, obstacle, vert, occ, emit;
         bit [63:0]         hist;
         inflated_cell_type due;
         w   = width_used();
         h   = height_used();
         r   = radius_used();
         pad = pad_in;
         // A pad that comes before the frame is complete is dropped.
         if (in_y < h && pad) return;
         // Once all pixels are in, every transfer only flushes.
         if (in_y >= h) pad = 1'b1;
         if (in_x >= w) begin
            rewind();
            return;
         end
         obstacle = !pad && red == 8'd0 && green == 8'd0 && blue == 8'd0;

         // Vertical OR over the column, centered radius rows back.
         hist = col_bits[in_x];
         vert = obstacle && in_y < h;
         for (int k = 0; k < 2 * r; k++) begin
            row = in_y - 1 - k;
            if (row >= 0 && row < h && hist[k]) vert = 1'b1;
         end
         col_bits[in_x] = {hist[62:0], obstacle};

         // Horizontal OR over the row window, clipped at the image border.
         s    = in_y * w + in_x;
         lag  = r * w + r;
         emit = s >= lag && out_row < h;
         if (emit) begin
            ex  = out_col;
            ey  = out_row;
            c0  = ex - r < 0 ? 0 : ex - r;
            c1  = ex + r > w - 1 ? w - 1 : ex + r;
            occ = 1'b0;
            for (int c = c0; c <= c1; c++) begin
               j = ex + r - c;
               if (j == 0) occ |= vert;
               else occ |= row_bits[j-1];
            end
            due.x         = 10'(ex);
            due.y         = 10'(ey);
            due.occupied  = occ;
            due.gray      = occ ? GRAY_OCCUPIED : GRAY_FREE;
            due.frame_end = ey == h - 1 && ex == w - 1;
            due_cells.push_back(due);
         end
         row_bits = {row_bits[62:0], vert};
         if (emit) begin
            if (due.frame_end) begin
               rewind();
               return;
            end
            out_col++;
            if (out_col >= w) begin
               out_col = 0;
               out_row++;
            end
         end

         in_x++;
         if (in_x >= w) begin
            in_x = 0;
            in_y++;
            if (in_y > 2047) rewind();
         end
      endfunction

      function void compare_field(string name, logic [9:0] want, logic [9:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      // Check one accepted result transfer against the oldest queued cell.
      function void match_cell(inflated_cell_type got);
         inflated_cell_type want;
         if (due_cells.size() == 0) begin
            $display("%0t: cell x=%0d y=%0d arrived, expected none", $time, got.x, got.y);
            errors++;
            return;
         end
         want = due_cells.pop_front();
         compare_field("out_x", want.x, got.x);
         compare_field("out_y", want.y, got.y);
         compare_field("occupied", want.occupied, got.occupied);
         compare_field("gray", want.gray, got.gray);
         compare_field("frame_end", want.frame_end, got.frame_end);
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [7:0]          req_red;
   logic [7:0]          req_green;
   logic [7:0]          req_blue;
   logic                req_pad;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [9:0]          rsp_out_x;
   logic [9:0]          rsp_out_y;
   logic                rsp_occupied;
   logic [7:0]          rsp_gray;
   logic                rsp_frame_end;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   inflation_tracker_type tracker = new();
   bit                    no_idling;
   int                    random_items;

   occupancy_grid_square_dilation dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Overall time limit.
   initial begin
      #4_000_000;
      $display("occupancy_grid_square_dilation_test NOT OK");
      $finish;
   end

   // Result side backpressure in random bursts.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         int  span;
         bit  hold;
         span = $urandom_range(1, 10);
         hold = !no_idling && $urandom_range(0, 2) == 0;
         repeat (span) begin
            @(negedge clock);
            rsp_stall <= hold;
         end
      end
   end

   // Both channels are observed at the rising edge; inputs are noted first.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.take_pixel(req_red, req_green, req_blue, req_pad);
         if (rsp_valid && !rsp_stall)
            tracker.match_cell({rsp_out_x, rsp_out_y, rsp_occupied, rsp_gray, rsp_frame_end});
      end
   end

   // Present one item and hold it until its transfer, after an optional gap.
   task automatic send_item(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input logic pad);
      int gap;
      gap = (!no_idling && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= red;
      req_green <= green;
      req_blue  <= blue;
      req_pad   <= pad;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Black with the given chance in thousandths, near black now and then, else random.
   task automatic send_pixel(input int density);
      logic [23:0] rgb;
      int          roll;
      roll = $urandom_range(0, 999);
      rgb  = 24'($urandom);
      if (roll < density) rgb = '0;
      else if (roll < density + 30) rgb = 24'd1 << $urandom_range(0, 23);
      send_item(rgb[23:16], rgb[15:8], rgb[7:0], 1'b0);
   endtask

   // Stop sending and wait until every queued cell has come out.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input int value);
      logic [31:0] data;
      data = $urandom;
      if (idx == REG_INFLATION_RADIUS) data[4:0] = value[4:0];
      else data[10:0] = value[10:0];
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tracker.write_reg(idx, data);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [1:0] idx);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== tracker.reg_value(idx)) begin
         $display("%0t: register %0d read mismatch, expected %0d, actual %0d",
                  $time, idx, tracker.reg_value(idx), csr_prdata);
         tracker.errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write the selected registers while idle, then read all three back.
   task automatic configure(input int wv, input int hv, input int rv, input bit [2:0] which);
      wait_idle();
      if (which[0]) csr_write(REG_IMAGE_WIDTH, wv);
      if (which[1]) csr_write(REG_IMAGE_HEIGHT, hv);
      if (which[2]) csr_write(REG_INFLATION_RADIUS, rv);
      csr_read(REG_IMAGE_WIDTH);
      csr_read(REG_IMAGE_HEIGHT);
      csr_read(REG_INFLATION_RADIUS);
   endtask

   // One frame of pixels and its flush tail; a cut stops it after that many pixels.
   task automatic send_frame(input int density, input bit noisy, input bit counted,
                             input int cut);
      int total, tail;
      total = tracker.width_used() * tracker.height_used();
      tail  = tracker.flush_length();
      for (int i = 0; i < total; i++) begin
         if (i == cut) return;
         // A pad before the frame is complete must leave no trace.
         if (noisy && $urandom_range(0, 40) == 0)
            send_item(8'($urandom) & 8'($urandom), 8'd0, 8'($urandom), 1'b1);
         if (noisy && !no_idling && $urandom_range(0, 300) == 0) wait_idle();
         send_pixel(density);
         if (counted) random_items++;
      end
      // During the flush, pixels are taken as pads.
      for (int i = 0; i < tail; i++) begin
         case ($urandom_range(0, 5))
            0: send_pixel(density);
            1: send_item(8'd0, 8'd0, 8'd0, 1'b1);
            default: send_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
         endcase
         if (counted) random_items++;
      end
      // A pad after the frame end is dropped as well.
      if (noisy && $urandom_range(0, 5) == 0) send_item(8'd0, 8'd0, 8'd0, 1'b1);
   endtask

   initial begin
      int         wv, hv, rv, cut, density;
      bit [2:0]   which;
      bit         need_setup;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_red     = '0;
      req_green   = '0;
      req_blue    = '0;
      req_pad     = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      no_idling   = 1'b0;
      random_items = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Registers come out of reset with their default map settings.
      csr_read(REG_IMAGE_WIDTH);
      csr_read(REG_IMAGE_HEIGHT);
      csr_read(REG_INFLATION_RADIUS);

      // Small 3x2 map with radius 1: obstacles, near black pixels and the flush rules.
      configure(3, 2, 1, 3'b111);
      send_item(8'd0, 8'd0, 8'd0, 1'b1);
      send_item(8'd0, 8'd0, 8'd0, 1'b0);
      send_item(8'd1, 8'd0, 8'd0, 1'b0);
      send_item(8'd0, 8'd128, 8'd0, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 1'b1);
      send_item(8'd0, 8'd0, 8'd255, 1'b0);
      send_item(8'd255, 8'd255, 8'd255, 1'b0);
      wait_idle();
      send_item(8'd0, 8'd0, 8'd0, 1'b0);
      send_item(8'd255, 8'd0, 8'd255, 1'b1);
      send_item(8'd0, 8'd0, 8'd0, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 1'b1);
      send_item(8'd0, 8'd0, 8'd0, 1'b1);
      send_item(8'd0, 8'd0, 8'd0, 1'b1);

      // Radius zero gives each cell on its own pixel; then a restart mid frame.
      configure(2, 2, 0, 3'b111);
      send_item(8'd0, 8'd0, 8'd0, 1'b0);
      send_item(8'd255, 8'd0, 8'd0, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 1'b0);
      send_item(8'd255, 8'd255, 8'd255, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 1'b0);
      configure(0, 0, 1, 3'b100);
      send_frame(100, 1'b0, 1'b0, -1);

      // Extreme sizes, including values that are clamped; the large maps are cut short.
      configure(1024, 1, 0, 3'b111);
      send_frame(10, 1'b0, 1'b0, 40);
      configure(0, 2047, 2, 3'b111);
      send_frame(100, 1'b0, 1'b0, 40);
      configure(2047, 0, 0, 3'b111);
      send_frame(50, 1'b0, 1'b0, 40);
      configure(3, 0, 31, 3'b111);
      send_frame(300, 1'b0, 1'b0, -1);
      configure(1, 1, 16, 3'b111);
      send_frame(500, 1'b0, 1'b0, -1);
      configure(4, 36, 16, 3'b111);
      send_frame(20, 1'b0, 1'b0, -1);

      // Random frames, some cut short, some back to back with the same settings.
      need_setup = 1'b1;
      while (random_items < 650) begin
         if (random_items >= 520) no_idling = 1'b1;
         if (need_setup || $urandom_range(0, 3) != 0) begin
            wv = $urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 24);
            hv = $urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 16);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: rv = $urandom_range(0, 3);
               6, 7, 8: rv = $urandom_range(4, 16);
               default: rv = $urandom_range(17, 31);
            endcase
            which = need_setup ? 3'b111 : 3'($urandom_range(1, 7));
            configure(wv, hv, rv, which);
         end
         case ($urandom_range(0, 3))
            0: density = 0;
            1: density = 30;
            2: density = 100;
            default: density = 400;
         endcase
         cut = -1;
         if ($urandom_range(0, 7) == 0)
            cut = $urandom_range(0, tracker.width_used() * tracker.height_used() - 1);
         send_frame(density, 1'b1, 1'b1, cut);
         need_setup = cut >= 0;
      end

      wait_idle();
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("occupancy_grid_square_dilation_test OK");
      end else begin
         $display("occupancy_grid_square_dilation_test NOT OK");
      end
      $finish;
   end

endmodule
